>>> hdl/seq_pkg.sv
// ----------------------------------------------------------------------------
// seq_pkg
// Shared types and codes for the sorted event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package seq_pkg;

   localparam int TIME_W  = 48;
   localparam int COUNT_W = 5;   // width of the reported entry count

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE       = 2'd0,
      STAT_FULL_REJ   = 2'd1,
      STAT_EMPTY_REJ  = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] ev_time;
      logic              ev_kind;
   } entry_type;

   // Broadcast from the control to every cell of the chain.
   typedef struct packed {
      logic      ins;      // qualified insert this cycle
      logic      rem;      // qualified remove this cycle
      entry_type new_ent;  // entry being inserted
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> hdl/seq_if.sv
// ----------------------------------------------------------------------------
// seq_req_if / seq_rsp_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
`default_nettype none

interface seq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [seq_pkg::TIME_W-1:0]  event_time;
   logic                        event_kind;

   modport source (output valid, output command, output event_time,
                   output event_kind, input ready);
   modport sink   (input valid, input command, input event_time,
                   input event_kind, output ready);
endinterface

interface seq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic                        queue_empty;
   logic [seq_pkg::TIME_W-1:0]  head_time;
   logic                        head_kind;
   logic [seq_pkg::COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output queue_empty,
                   output head_time, output head_kind, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input queue_empty,
                   input head_time, input head_kind, input entry_count,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/seq_cell.sv
// ----------------------------------------------------------------------------
// seq_cell
// One slot of the sorted chain. Keeps, takes the new entry, or takes a
// neighbor's entry, decided locally from its own compare and its left
// neighbor's compare.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_cell (
   input  wire logic                  clock,
   input  wire seq_pkg::cell_ctl_type ctl,
   input  wire logic                  slot_valid,
   input  wire logic                  left_ge,
   input  wire seq_pkg::entry_type    left_ent,
   input  wire seq_pkg::entry_type    right_ent,
   output      logic                  ge,
   output      seq_pkg::entry_type    ent,
   output      seq_pkg::entry_type    ent_next
);

   seq_pkg::entry_type ent_ff;
   seq_pkg::entry_type ent_in;

   // Empty slots count as "at or after" the new time, so the first one
   // past the tail receives the insert when no stored entry is at or after it.
   assign ge = !slot_valid || (ent_ff.ev_time >= ctl.new_ent.ev_time);

   always_comb begin
      ent_in = ent_ff;
      if (ctl.ins) begin
         if (left_ge) begin
            ent_in = left_ent;
         end else if (ge) begin
            ent_in = ctl.new_ent;
         end
      end else if (ctl.rem) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent      = ent_ff;
   assign ent_next = ent_in;

endmodule

`default_nettype wire

>>> hdl/sorted_event_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_event_queue_top
// Event queue kept sorted by ascending time in a chain of compare cells.
// The result of a transaction is registered and valid in the cycle after acceptance.
// Throughput: one transaction per cycle while the receiver takes results; every
// cell compares against the new time in parallel and shifts in the same cycle.
// A result held off by the receiver stalls the input.
// Reset clears the entry count and the result valid; entry storage is not
// cleared and is only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_queue_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   seq_req_if.sink     req_bus,
   seq_rsp_if.source   rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   seq_pkg::cell_ctl_type ctl;
   seq_pkg::entry_type    ents      [CAPACITY];
   seq_pkg::entry_type    ents_next [CAPACITY];
   logic [CAPACITY-1:0]   ge;
   logic [CAPACITY-1:0]   slot_valid;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic [1:0]            status_ff;
   logic                  empty_ff;
   logic [seq_pkg::TIME_W-1:0] head_time_ff;
   logic                  head_kind_ff;
   logic [seq_pkg::COUNT_W-1:0] count_out_ff;

   logic                  accept;
   logic                  is_full;
   logic                  is_empty;
   seq_pkg::status_type   status_in;
   logic [CNT_W+seq_pkg::COUNT_W-1:0] count_wide;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_full       = (count_ff == CNT_W'(CAPACITY));
   assign is_empty      = (count_ff == '0);

   always_comb begin
      ctl.ins             = 1'b0;
      ctl.rem             = 1'b0;
      ctl.new_ent.ev_time = req_bus.event_time;
      ctl.new_ent.ev_kind = req_bus.event_kind;
      count_in            = count_ff;
      status_in           = seq_pkg::STAT_DONE;
      if (accept) begin
         unique case (seq_pkg::cmd_type'(req_bus.command))
            seq_pkg::CMD_INSERT: begin
               if (is_full) begin
                  status_in = seq_pkg::STAT_FULL_REJ;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            seq_pkg::CMD_REMOVE: begin
               if (is_empty) begin
                  status_in = seq_pkg::STAT_EMPTY_REJ;
               end else begin
                  ctl.rem  = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: status_in = seq_pkg::STAT_DONE;
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign slot_valid[i] = (count_ff > CNT_W'(i));

      seq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .slot_valid (slot_valid[i]),
         .left_ge    ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i-1]),
         .left_ent   (ents[(i == 0) ? 0 : i-1]),
         .right_ent  (ents[(i == CAPACITY-1) ? i : i+1]),
         .ge         (ge[i]),
         .ent        (ents[i]),
         .ent_next   (ents_next[i])
      );
   end

   assign count_wide = {{seq_pkg::COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         empty_ff     <= (count_in == '0);
         head_time_ff <= (count_in == '0) ? '0 : ents_next[0].ev_time;
         head_kind_ff <= (count_in == '0) ? 1'b0 : ents_next[0].ev_kind;
         count_out_ff <= count_wide[seq_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.queue_empty = empty_ff;
   assign rsp_bus.head_time   = head_time_ff;
   assign rsp_bus.head_kind   = head_kind_ff;
   assign rsp_bus.entry_count = count_out_ff;

   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.command == seq_pkg::CMD_INSERT && !is_full)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted insert did not grow the queue");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != seq_pkg::STAT_DONE) |=> $stable(count_ff))
      else $error("rejected transaction changed the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (ents[0].ev_time <= ents[1].ev_time))
      else $error("head entry out of order");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
